>>> rtl/core/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, word offsets and helpers for the gpio register controller.
// ----------------------------------------------------------------------------
package grc_pkg;

	localparam int NUM_PINS        = 54;
	localparam int PINS_PER_SELECT = 10;
	localparam int FSEL_WORDS      = 6;
	localparam int FIELD_BITS      = 3;
	localparam int FSEL_BITS       = PINS_PER_SELECT * FIELD_BITS;
	localparam int WORD_BITS       = 32;
	localparam int OFFSET_BITS     = 6;
	localparam int PULL_BITS       = 2;
	localparam int IN_TDATA_BITS   = 96;
	localparam int OUT_TDATA_BITS  = 248;

	localparam logic [FIELD_BITS-1:0] MODE_OUTPUT = 3'd1;

	localparam logic [PULL_BITS-1:0] PULL_DOWN = 2'd1;
	localparam logic [PULL_BITS-1:0] PULL_UP   = 2'd2;

	localparam logic [OFFSET_BITS-1:0] OFF_FSEL0   = 6'd0;
	localparam logic [OFFSET_BITS-1:0] OFF_FSEL1   = 6'd1;
	localparam logic [OFFSET_BITS-1:0] OFF_FSEL2   = 6'd2;
	localparam logic [OFFSET_BITS-1:0] OFF_FSEL3   = 6'd3;
	localparam logic [OFFSET_BITS-1:0] OFF_FSEL4   = 6'd4;
	localparam logic [OFFSET_BITS-1:0] OFF_FSEL5   = 6'd5;
	localparam logic [OFFSET_BITS-1:0] OFF_SET0    = 6'd7;
	localparam logic [OFFSET_BITS-1:0] OFF_SET1    = 6'd8;
	localparam logic [OFFSET_BITS-1:0] OFF_CLR0    = 6'd10;
	localparam logic [OFFSET_BITS-1:0] OFF_CLR1    = 6'd11;
	localparam logic [OFFSET_BITS-1:0] OFF_LEV0    = 6'd13;
	localparam logic [OFFSET_BITS-1:0] OFF_LEV1    = 6'd14;
	localparam logic [OFFSET_BITS-1:0] OFF_PUD     = 6'd37;
	localparam logic [OFFSET_BITS-1:0] OFF_PUDCLK0 = 6'd38;
	localparam logic [OFFSET_BITS-1:0] OFF_PUDCLK1 = 6'd39;

	typedef enum logic {
		ACC_READ  = 1'b0,
		ACC_WRITE = 1'b1
	} grc_kind_t;

	typedef struct packed {
		grc_kind_t               mode;
		logic [OFFSET_BITS-1:0]  word_offset;
		logic [WORD_BITS-1:0]    write_data;
		logic [NUM_PINS-1:0]     pin_inputs;
	} grc_access_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] read_data;
		logic [NUM_PINS-1:0]  drive_level;
		logic [NUM_PINS-1:0]  drive_enable;
		logic [NUM_PINS-1:0]  pull_up_mask;
		logic [NUM_PINS-1:0]  pull_down_mask;
	} grc_result_t;

	// mode fields of select word w that belong to existing pins
	function automatic logic [FSEL_BITS-1:0] fsel_valid(input int unsigned w);
		logic [FSEL_BITS-1:0] m;
		m = '0;
		for (int i = 0; i < PINS_PER_SELECT; i++) begin
			if (w * PINS_PER_SELECT + i < NUM_PINS)
				m[i*FIELD_BITS +: FIELD_BITS] = '1;
		end
		return m;
	endfunction

	// place a 32-bit bank word onto the pin vector
	function automatic logic [NUM_PINS-1:0] bank_bits(input logic bank,
		input logic [WORD_BITS-1:0] data);
		logic [2*WORD_BITS-1:0] wide;
		wide = bank ? {data, {WORD_BITS{1'b0}}} : {{WORD_BITS{1'b0}}, data};
		return wide[NUM_PINS-1:0];
	endfunction

endpackage

>>> rtl/core/grc_in_stage.sv
// ----------------------------------------------------------------------------
// grc_in_stage
// Input register for access beats, released when the register file commits.
// ----------------------------------------------------------------------------
module grc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  grc_pkg::grc_access_t in_acc,
	input  logic                advance,
	output logic                valid_s1,
	output grc_pkg::grc_access_t acc_s1
);
	import grc_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			acc_s1 <= in_acc;
		end
	end

endmodule

>>> rtl/core/grc_regfile.sv
// ----------------------------------------------------------------------------
// grc_regfile
// Register state of the controller: decode, masked update and read mux.
// ----------------------------------------------------------------------------
module grc_regfile (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  grc_pkg::grc_access_t acc,
	output grc_pkg::grc_result_t res
);
	import grc_pkg::*;

	logic [FSEL_BITS-1:0] fsel_q [FSEL_WORDS];
	logic [FSEL_BITS-1:0] fsel_n [FSEL_WORDS];
	logic [NUM_PINS-1:0]  latch_q, latch_n;
	logic [PULL_BITS-1:0] pud_q, pud_n;
	logic [NUM_PINS-1:0]  up_q, up_n;
	logic [NUM_PINS-1:0]  down_q, down_n;
	logic [WORD_BITS-1:0] rd;
	logic [NUM_PINS-1:0]  sel;
	logic [NUM_PINS-1:0]  enable;
	logic [2*WORD_BITS-1:0] pins_wide;
	logic                 wr;

	assign wr        = (acc.mode == ACC_WRITE);
	assign pins_wide = {{(2*WORD_BITS-NUM_PINS){1'b0}}, acc.pin_inputs};

	always_comb begin
		for (int w = 0; w < FSEL_WORDS; w++)
			fsel_n[w] = fsel_q[w];
		latch_n = latch_q;
		pud_n   = pud_q;
		up_n    = up_q;
		down_n  = down_q;
		rd      = '0;
		sel     = bank_bits(acc.word_offset[0] ^ 1'b0, acc.write_data);

		case (acc.word_offset)
			OFF_FSEL0, OFF_FSEL1, OFF_FSEL2, OFF_FSEL3, OFF_FSEL4, OFF_FSEL5: begin
				for (int w = 0; w < FSEL_WORDS; w++) begin
					if (acc.word_offset == OFFSET_BITS'(w)) begin
						if (wr)
							fsel_n[w] = acc.write_data[FSEL_BITS-1:0] & fsel_valid(w);
						else
							rd = {{(WORD_BITS-FSEL_BITS){1'b0}}, fsel_q[w]};
					end
				end
			end
			OFF_SET0, OFF_SET1: begin
				if (wr)
					latch_n = latch_q | bank_bits(acc.word_offset == OFF_SET1,
						acc.write_data);
			end
			OFF_CLR0, OFF_CLR1: begin
				if (wr)
					latch_n = latch_q & ~bank_bits(acc.word_offset == OFF_CLR1,
						acc.write_data);
			end
			OFF_LEV0: begin
				if (!wr)
					rd = pins_wide[WORD_BITS-1:0];
			end
			OFF_LEV1: begin
				if (!wr)
					rd = pins_wide[2*WORD_BITS-1:WORD_BITS];
			end
			OFF_PUD: begin
				if (wr)
					pud_n = acc.write_data[PULL_BITS-1:0];
				else
					rd = {{(WORD_BITS-PULL_BITS){1'b0}}, pud_q};
			end
			OFF_PUDCLK0, OFF_PUDCLK1: begin
				if (wr) begin
					sel    = bank_bits(acc.word_offset == OFF_PUDCLK1, acc.write_data);
					// reserved code and off both clear the selected pins
					up_n   = (up_q & ~sel) | ((pud_q == PULL_UP) ? sel : '0);
					down_n = (down_q & ~sel) | ((pud_q == PULL_DOWN) ? sel : '0);
				end
			end
			default: begin
				rd = '0;
			end
		endcase
	end

	// enables follow the select words after this beat's update
	always_comb begin
		enable = '0;
		for (int w = 0; w < FSEL_WORDS; w++) begin
			for (int i = 0; i < PINS_PER_SELECT; i++) begin
				if (w * PINS_PER_SELECT + i < NUM_PINS)
					enable[w*PINS_PER_SELECT+i] =
						(fsel_n[w][i*FIELD_BITS +: FIELD_BITS] == MODE_OUTPUT);
			end
		end
	end

	assign res.read_data      = rd;
	assign res.drive_level    = latch_n;
	assign res.drive_enable   = enable;
	assign res.pull_up_mask   = up_n;
	assign res.pull_down_mask = down_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < FSEL_WORDS; w++)
				fsel_q[w] <= '0;
			latch_q <= '0;
			pud_q   <= '0;
			up_q    <= '0;
			down_q  <= '0;
		end else if (commit) begin
			for (int w = 0; w < FSEL_WORDS; w++)
				fsel_q[w] <= fsel_n[w];
			latch_q <= latch_n;
			pud_q   <= pud_n;
			up_q    <= up_n;
			down_q  <= down_n;
		end
	end

endmodule

>>> rtl/core/grc_out_stage.sv
// ----------------------------------------------------------------------------
// grc_out_stage
// Result register holding one beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module grc_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  grc_pkg::grc_result_t in_res,
	output logic                 out_valid,
	input  logic                 out_ready,
	output grc_pkg::grc_result_t out_res
);
	import grc_pkg::*;

	logic valid_s2;
	grc_result_t res_s2;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s2 <= in_res;
		end
	end

endmodule

>>> rtl/core/gpio_register_controller_unit.sv
// ----------------------------------------------------------------------------
// gpio_register_controller_unit
// 54-pin gpio controller behind a word-access stream, one result per access.
// ----------------------------------------------------------------------------
// Each access beat (read or write to one of 15 register words) produces one
// result beat carrying the read data and the pin drive, enable and pull masks
// as they stand after the access. The unit takes one access per clock while
// results are not stalled; each access passes through the input register,
// the single decode-and-update pass and the result register.
// A stalled result holds one further access in the input register.
module gpio_register_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// word_offset[5:0], write_data[37:6], pin_inputs[91:38], zero fill
	input  logic [grc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	// mode (0 read, 1 write)
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// read_data[31:0], drive_level[85:32], drive_enable[139:86],
	// pull_up_mask[193:140], pull_down_mask[247:194]
	output logic [grc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
	import grc_pkg::*;

	grc_access_t in_acc, acc_s1;
	grc_result_t res, out_res;
	logic        valid_s1;
	logic        out_ready;
	logic        advance;

	assign in_acc.mode        = grc_kind_t'(s_axis_tuser[0]);
	assign in_acc.word_offset = s_axis_tdata[OFFSET_BITS-1:0];
	assign in_acc.write_data  = s_axis_tdata[OFFSET_BITS +: WORD_BITS];
	assign in_acc.pin_inputs  = s_axis_tdata[OFFSET_BITS+WORD_BITS +: NUM_PINS];

	assign advance = valid_s1 && out_ready;

	grc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_acc   (in_acc),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.acc_s1   (acc_s1)
	);

	grc_regfile u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.acc    (acc_s1),
		.res    (res)
	);

	grc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (out_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.pull_down_mask, out_res.pull_up_mask,
		out_res.drive_enable, out_res.drive_level, out_res.read_data};

endmodule
